FILE: design/rpv_pkg.sv
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared types, constants and the first-quadrant sine/cosine generator used to
// build the rotation table of the vertex rotate-and-project unit.
// ----------------------------------------------------------------------------
package rpv_pkg;

	localparam int TRIG_FRAC = 14;
	localparam int TRIG_W    = TRIG_FRAC + 2;
	localparam int VERT_W    = 16;
	localparam int SPAN_W    = 10;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 2;
	// Divider pipeline: one range stage, one stage per quotient bit, one output stage.
	localparam int DIV_LAT   = OUT_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [SPAN_W-1:0] WIDTH_RESET  = 10'd100;
	localparam logic [SPAN_W-1:0] HEIGHT_RESET = 10'd24;

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint SDEN [5] = '{110, 72, 42, 20, 6};
	localparam longint CDEN [6] = '{132, 90, 56, 30, 12, 2};

	typedef logic signed [TRIG_W-1:0] trig_t;

	typedef struct packed {
		trig_t              sin_v;
		trig_t              cos_v;
		logic [SPAN_W-1:0]  width;
		logic [SPAN_W-1:0]  height;
	} cfg_t;

	function automatic longint q30_to_q14(input longint v);
		longint r;
		r = (v < 0) ? 64'sd0 : v;
		return (r + (64'sd1 <<< (30 - TRIG_FRAC - 1))) >>> (30 - TRIG_FRAC);
	endfunction

	// Returns {sin, cos} of x (Q30 radians in the first quadrant), each Q14 unsigned.
	function automatic logic [2*(TRIG_FRAC+1)-1:0] quad_trig(input longint x);
		longint x2;
		longint t;
		longint s;
		longint c;
		x2 = (x * x) >>> 30;
		t = Q30_ONE;
		for (int i = 0; i < 5; i++) begin
			t = Q30_ONE - ((x2 * t) >>> 30) / SDEN[i];
		end
		s = q30_to_q14((x * t) >>> 30);
		t = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			t = Q30_ONE - ((x2 * t) >>> 30) / CDEN[i];
			if (t < 0) begin
				t = 0;
			end
		end
		c = q30_to_q14(t);
		return {s[TRIG_FRAC:0], c[TRIG_FRAC:0]};
	endfunction

endpackage

FILE: design/rpv_cfg.sv
// ----------------------------------------------------------------------------
// rpv_cfg
// Configuration registers. An angle write looks the angle up in the sine and
// cosine table and keeps the signed values, so the datapath sees them directly.
// ----------------------------------------------------------------------------
module rpv_cfg #(
	parameter int ANGLE_BITS = 12,
	parameter int DATA_W     = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [rpv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]                 cfg_data,
	output rpv_pkg::cfg_t                     cfg
);

	localparam int QB = ANGLE_BITS - 2;
	localparam int QN = 1 << QB;
	localparam int EW = 2 * (rpv_pkg::TRIG_FRAC + 1);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef logic [EW-1:0] rom_t [QN];

	function automatic rom_t build_rom();
		rom_t   rom;
		longint x;
		for (int r = 0; r < QN; r++) begin
			x = (longint'(r) * rpv_pkg::HALF_PI_Q30) >>> QB;
			rom[r] = rpv_pkg::quad_trig(x);
		end
		return rom;
	endfunction

	localparam rom_t TRIG_ROM = build_rom();

	logic [EW-1:0]       ent;
	logic [1:0]          quad;
	rpv_pkg::trig_t      bs;
	rpv_pkg::trig_t      bc;
	rpv_pkg::trig_t      sin_n;
	rpv_pkg::trig_t      cos_n;

	assign ent  = TRIG_ROM[cfg_data[QB-1:0]];
	assign quad = cfg_data[ANGLE_BITS-1 -: 2];
	assign bs   = $signed({1'b0, ent[EW-1 -: rpv_pkg::TRIG_FRAC+1]});
	assign bc   = $signed({1'b0, ent[rpv_pkg::TRIG_FRAC:0]});

	always_comb begin
		case (quad)
			QUAD_0: begin sin_n = bs;  cos_n = bc;  end
			QUAD_1: begin sin_n = bc;  cos_n = -bs; end
			QUAD_2: begin sin_n = -bs; cos_n = -bc; end
			QUAD_3: begin sin_n = -bc; cos_n = bs;  end
			default: begin sin_n = bs; cos_n = bc;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.sin_v  <= '0;
			cfg.cos_v  <= rpv_pkg::trig_t'(1 << rpv_pkg::TRIG_FRAC);
			cfg.width  <= rpv_pkg::WIDTH_RESET;
			cfg.height <= rpv_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rpv_pkg::REG_ANGLE: begin
					cfg.sin_v <= sin_n;
					cfg.cos_v <= cos_n;
				end
				rpv_pkg::REG_WIDTH:  cfg.width  <= cfg_data[rpv_pkg::SPAN_W-1:0];
				rpv_pkg::REG_HEIGHT: cfg.height <= cfg_data[rpv_pkg::SPAN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: design/rpv_div.sv
// ----------------------------------------------------------------------------
// rpv_div
// Pipelined floor division with 16-bit signed saturation. The numerator is
// biased by 2^15 times the divisor, then one quotient bit is resolved per stage.
// ----------------------------------------------------------------------------
module rpv_div #(
	parameter int NW = 45,
	parameter int DW = 34
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [NW-1:0]                 num,
	input  logic [DW-1:0]                        den,
	input  logic                                 kill,
	output logic signed [rpv_pkg::OUT_W-1:0]     quo
);

	localparam int QW = rpv_pkg::OUT_W;
	localparam int RW = DW + QW;
	localparam int EW = ((NW > RW) ? NW : RW) + 2;

	logic signed [EW-1:0] num_w;
	logic signed [EW-1:0] lim_w;
	logic signed [EW-1:0] m_w;

	assign num_w = EW'(num);
	assign lim_w = $signed({{(EW-DW){1'b0}}, den} << (QW - 1));
	assign m_w   = num_w + lim_w;

	logic [RW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic          hi_s   [QW+1];
	logic          lo_s   [QW+1];
	logic          kill_s [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= m_w[RW-1:0];
			den_s[0]  <= den;
			q_s[0]    <= '0;
			hi_s[0]   <= (num_w >= lim_w);
			lo_s[0]   <= (num_w < -lim_w);
			kill_s[0] <= kill;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_bit
		localparam int B = QW - k;
		logic [RW-1:0] trial;
		logic          take;
		assign trial = {{QW{1'b0}}, den_s[k-1]} << B;
		assign take  = (rem_s[k-1] >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (rem_s[k-1] - trial) : rem_s[k-1];
				q_s[k]    <= q_s[k-1] | (QW'(take) << B);
				den_s[k]  <= den_s[k-1];
				hi_s[k]   <= hi_s[k-1];
				lo_s[k]   <= lo_s[k-1];
				kill_s[k] <= kill_s[k-1];
			end
		end
	end

	// Flipping the top bit removes the 2^15 bias.
	always_ff @(posedge clk) begin
		if (en) begin
			if (kill_s[QW]) begin
				quo <= '0;
			end else if (hi_s[QW]) begin
				quo <= {1'b0, {(QW-1){1'b1}}};
			end else if (lo_s[QW]) begin
				quo <= {1'b1, {(QW-1){1'b0}}};
			end else begin
				quo <= $signed({~q_s[QW][QW-1], q_s[QW][QW-2:0]});
			end
		end
	end

endmodule

FILE: design/rotate_project_vertex_unit.sv
// ----------------------------------------------------------------------------
// rotate_project_vertex_unit
// Rotates a vertex about the Y axis and projects it onto a character screen.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one vertex (x, y, z, signed Q2.14). Each input
// beat gives exactly one output beat on m_axis with the floored, saturated
// screen column and row; tuser is set when the offset depth is zero or
// negative, and then both coordinates are zero.
// The cfg channel writes the angle, screen width and screen height; cfg_ready
// is always high, and writes must be made while no vertex is in flight; the
// unit itself does not enforce this. An angle write looks up sine and cosine
// in the same cycle, so the next beat uses it. The edge that accepts an input
// beat loads the first of three multiply-and-add stages, and the vertex then
// passes 18 stages in the floor dividers (range check, one quotient bit per
// stage, output register) before its output beat is offered. Throughput is
// one vertex per cycle unless the output stalls; the dividers set the depth.
// When m_axis_tready is low with a beat waiting, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads angle 0, width 100 and height 24.
// ----------------------------------------------------------------------------
module rotate_project_vertex_unit #(
	parameter int ANGLE_BITS      = 12,
	parameter int COORD_FRAC_BITS = 14
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  logic [47:0]                               s_axis_tdata,  // vertex_x, vertex_y, vertex_z
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	output logic [31:0]                               m_axis_tdata,  // screen_col, screen_row
	output logic                                      m_axis_tuser,  // behind_viewer
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [rpv_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [((ANGLE_BITS > 10) ? ANGLE_BITS : 10)-1:0] cfg_data
);

	localparam int DATA_W = (ANGLE_BITS > 10) ? ANGLE_BITS : 10;
	localparam int TF     = rpv_pkg::TRIG_FRAC;
	localparam int VW     = rpv_pkg::VERT_W;
	localparam int PW     = 2 * VW;
	localparam int SW     = ((COORD_FRAC_BITS + TF > 31) ? COORD_FRAC_BITS + TF : 31) + 2;
	localparam int DW     = SW + 1;
	localparam int NW     = SW + rpv_pkg::SPAN_W + 2;
	localparam int LAT    = rpv_pkg::DIV_LAT;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (COORD_FRAC_BITS + TF - 1);

	rpv_pkg::cfg_t cfg;

	rpv_cfg #(
		.ANGLE_BITS (ANGLE_BITS),
		.DATA_W     (DATA_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready = 1'b1;

	logic            en;
	logic [LAT-1:0]  vdiv_q;
	logic            v_s1;
	logic            v_s2;
	logic            v_s3;

	assign en            = !vdiv_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vdiv_q[LAT-1];

	logic signed [VW-1:0] vx;
	logic signed [VW-1:0] vy;
	logic signed [VW-1:0] vz;
	rpv_pkg::trig_t       sin_w;
	rpv_pkg::trig_t       cos_w;

	assign vx    = $signed(s_axis_tdata[15:0]);
	assign vy    = $signed(s_axis_tdata[31:16]);
	assign vz    = $signed(s_axis_tdata[47:32]);
	assign sin_w = cfg.sin_v;
	assign cos_w = cfg.cos_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			vdiv_q <= '0;
		end else if (en) begin
			v_s1   <= s_axis_tvalid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			vdiv_q <= {vdiv_q[LAT-2:0], v_s3};
		end
	end

	logic signed [PW-1:0] p_xc_s1;
	logic signed [PW-1:0] p_zs_s1;
	logic signed [PW-1:0] p_xs_s1;
	logic signed [PW-1:0] p_zc_s1;
	logic signed [VW-1:0] vy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_xc_s1 <= vx * cos_w;
			p_zs_s1 <= vz * sin_w;
			p_xs_s1 <= vx * sin_w;
			p_zc_s1 <= vz * cos_w;
			vy_s1   <= vy;
		end
	end

	logic signed [SW-1:0] xr_s2;
	logic signed [SW-1:0] yr_s2;
	logic signed [SW-1:0] d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s2 <= SW'(p_xc_s1) - SW'(p_zs_s1);
			yr_s2 <= SW'(vy_s1) <<< TF;
			d_s2  <= SW'(p_xs_s1) + SW'(p_zc_s1) + HALF;
		end
	end

	logic signed [SW:0]           sum_x;
	logic signed [SW:0]           sum_y;
	logic signed [rpv_pkg::SPAN_W:0] w_w;
	logic signed [rpv_pkg::SPAN_W:0] h_w;

	assign sum_x = (SW+1)'(xr_s2) + (SW+1)'(d_s2);
	assign sum_y = (SW+1)'(yr_s2) + (SW+1)'(d_s2);
	assign w_w   = $signed({1'b0, cfg.width});
	assign h_w   = $signed({1'b0, cfg.height});

	logic signed [NW-1:0] nx_s3;
	logic signed [NW-1:0] ny_s3;
	logic [DW-1:0]        den_s3;
	logic                 kill_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3   <= NW'(sum_x) * NW'(w_w);
			ny_s3   <= NW'(sum_y) * NW'(h_w);
			den_s3  <= {d_s2, 1'b0};
			kill_s3 <= (d_s2 <= 0);
		end
	end

	logic signed [rpv_pkg::OUT_W-1:0] col;
	logic signed [rpv_pkg::OUT_W-1:0] row;
	logic [LAT-1:0]                   kill_q;

	rpv_div #(.NW(NW), .DW(DW)) u_div_col (
		.clk  (clk),
		.en   (en),
		.num  (nx_s3),
		.den  (den_s3),
		.kill (kill_s3),
		.quo  (col)
	);

	rpv_div #(.NW(NW), .DW(DW)) u_div_row (
		.clk  (clk),
		.en   (en),
		.num  (ny_s3),
		.den  (den_s3),
		.kill (kill_s3),
		.quo  (row)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			kill_q <= {kill_q[LAT-2:0], kill_s3};
		end
	end

	assign m_axis_tdata = {row, col};
	assign m_axis_tuser = kill_q[LAT-1];

endmodule

FILE: tb/rotate_project_vertex_checker.sv
// ----------------------------------------------------------------------------
// rotate_project_vertex_checker
// Watches the vertex, screen and register channels of the rotate-and-project
// unit, computes the screen position of every accepted vertex and compares
// each output beat, in order, with the oldest pending position.
// ----------------------------------------------------------------------------
module rotate_project_vertex_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // vertex_x, vertex_y, vertex_z
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // screen_col, screen_row
	input  logic        m_axis_tuser,   // behind_viewer
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          points_seen,
	output int          behind_seen
);

	typedef struct {
		logic signed [rpv_pkg::OUT_W-1:0] col;
		logic signed [rpv_pkg::OUT_W-1:0] row;
		logic                             behind;
	} screen_point_t;

	screen_point_t pending_points[$];
	logic [11:0]                angle;
	logic [rpv_pkg::SPAN_W-1:0] span_w;
	logic [rpv_pkg::SPAN_W-1:0] span_h;

	function automatic longint round_q30_q14(input longint v);
		if (v < 0) begin
			v = 0;
		end
		return (v + (64'sd1 <<< 15)) >>> 16;
	endfunction

	// Sine and cosine in Q14 for a 12-bit angle, first quadrant by polynomial.
	function automatic void angle_sin_cos(input logic [11:0] ph, output longint s,
			output longint c);
		longint sden[5] = '{110, 72, 42, 20, 6};
		longint cden[6] = '{132, 90, 56, 30, 12, 2};
		longint one;
		longint x;
		longint x2;
		longint t;
		longint bs;
		longint bc;
		one = 64'sd1 <<< 30;
		x = (longint'(ph[9:0]) * 64'sd1686629713) >>> 10;
		x2 = (x * x) >>> 30;
		t = one;
		for (int i = 0; i < 5; i++) begin
			t = one - ((x2 * t) >>> 30) / sden[i];
		end
		bs = round_q30_q14((x * t) >>> 30);
		t = one;
		for (int i = 0; i < 6; i++) begin
			t = one - ((x2 * t) >>> 30) / cden[i];
			if (t < 0) begin
				t = 0;
			end
		end
		bc = round_q30_q14(t);
		case (ph[11:10])
			2'd0: begin s = bs;  c = bc;  end
			2'd1: begin s = bc;  c = -bs; end
			2'd2: begin s = -bs; c = -bc; end
			default: begin s = -bc; c = bs; end
		endcase
	endfunction

	function automatic longint floor_quotient(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic screen_point_t project_vertex(input logic [47:0] v);
		screen_point_t p;
		longint vx;
		longint vy;
		longint vz;
		longint s;
		longint c;
		longint xr;
		longint yr;
		longint depth;
		vx = longint'($signed(v[15:0]));
		vy = longint'($signed(v[31:16]));
		vz = longint'($signed(v[47:32]));
		angle_sin_cos(angle, s, c);
		xr = vx * c - vz * s;
		yr = vy * (64'sd1 <<< 14);
		depth = vx * s + vz * c + (64'sd1 <<< 27);
		if (depth <= 0) begin
			p.col = '0;
			p.row = '0;
			p.behind = 1'b1;
		end else begin
			p.col = clamp16(floor_quotient((xr + depth) * longint'(span_w), 2 * depth));
			p.row = clamp16(floor_quotient((yr + depth) * longint'(span_h), 2 * depth));
			p.behind = 1'b0;
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_point_t want;
		logic signed [15:0] got_col;
		logic signed [15:0] got_row;
		if (!arst_n) begin
			angle = '0;
			span_w = rpv_pkg::WIDTH_RESET;
			span_h = rpv_pkg::HEIGHT_RESET;
			pending_points.delete();
			errors = 0;
			points_seen = 0;
			behind_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rpv_pkg::REG_ANGLE:  angle = cfg_data;
					rpv_pkg::REG_WIDTH:  span_w = cfg_data[rpv_pkg::SPAN_W-1:0];
					rpv_pkg::REG_HEIGHT: span_h = cfg_data[rpv_pkg::SPAN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_points.push_back(project_vertex(s_axis_tdata));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_col = m_axis_tdata[15:0];
				got_row = m_axis_tdata[31:16];
				points_seen++;
				if (m_axis_tuser) begin
					behind_seen++;
				end
				if (pending_points.size() == 0) begin
					$error("screen beat with no vertex pending: col %0d row %0d behind %0b",
						got_col, got_row, m_axis_tuser);
					errors++;
				end else begin
					want = pending_points.pop_front();
					if (got_col !== want.col) begin
						$error("screen_col: expected %0d, got %0d", want.col, got_col);
						errors++;
					end
					if (got_row !== want.row) begin
						$error("screen_row: expected %0d, got %0d", want.row, got_row);
						errors++;
					end
					if (m_axis_tuser !== want.behind) begin
						$error("behind_viewer: expected %0b, got %0b", want.behind,
							m_axis_tuser);
						errors++;
					end
				end
			end
		end
		pending = pending_points.size();
	end

endmodule

FILE: tb/rotate_project_vertex_unit_test.sv
// ----------------------------------------------------------------------------
// rotate_project_vertex_unit_test
// Drives vertices and register writes into the rotate-and-project unit under
// random idling on both streams, across several angle and screen settings,
// and leaves the checking of each beat to the channel checker.
// ----------------------------------------------------------------------------
module rotate_project_vertex_unit_test;

	localparam logic [rpv_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // vertex_x, vertex_y, vertex_z
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // screen_col, screen_row
	logic        m_axis_tuser;        // behind_viewer
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	int errors;
	int pending;
	int points_seen;
	int behind_seen;
	int tx_idle_pct = 38;
	int rx_idle_pct = 55;
	int rx_hold_cycles = 0;
	int sent = 0;

	rotate_project_vertex_unit dut (.*);

	rotate_project_vertex_checker checker_i (.*);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	// Receiver side: random backpressure, or a long hold when one is requested.
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_axis_tready = 1'b0;
				rx_hold_cycles--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Called at a falling edge; returns at a falling edge after the beat.
	task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {z, y, x};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		sent++;
	endtask

	task automatic drain;
		wait (pending == 0);
		@(negedge clk);
		repeat (rpv_pkg::DIV_LAT + 8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_screen(input logic [11:0] ang, input logic [11:0] w,
			input logic [11:0] h);
		drain();
		write_reg(rpv_pkg::REG_ANGLE, ang);
		write_reg(rpv_pkg::REG_WIDTH, w);
		write_reg(rpv_pkg::REG_HEIGHT, h);
	endtask

	task automatic send_random_vertex;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		if ($urandom_range(9) < 6) begin
			// Mostly in front of the viewer, where the projection is exercised.
			x = 16'($signed($urandom_range(32768)) - 16384);
			y = 16'($signed($urandom_range(32768)) - 16384);
			z = 16'($signed($urandom_range(20480)) - 4096);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
			z = 16'($urandom);
		end
		send_vertex(x, y, z);
	endtask

	task automatic random_burst(input int count);
		for (int i = 0; i < count; i++) begin
			if (sent >= 280 && sent < 530) begin
				tx_idle_pct = 55;
				rx_idle_pct = 38;
			end else if (sent >= 530) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send_random_vertex();
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings, then field extremes and a vertex right at zero depth.
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
		send_vertex(16'h8000, 16'h8000, 16'h8000);
		send_vertex(16'h0000, 16'h0000, 16'h0000);
		send_vertex(16'h0000, 16'h0000, 16'he000);
		send_vertex(16'h7fff, 16'h8000, 16'h0001);
		send_vertex(16'h8000, 16'h7fff, 16'h4000);
		send_vertex(16'h4000, 16'hc000, 16'hf000);
		send_vertex(16'h0000, 16'h0000, 16'hc000);

		set_screen(12'd0, 12'd1023, 12'd1023);
		send_vertex(16'h7fff, 16'h7fff, 16'he001);
		send_vertex(16'h8000, 16'h8000, 16'he001);
		send_vertex(16'h0100, 16'hff00, 16'h0000);

		// Zero spans, and the bits above the span width must be dropped.
		set_screen(12'd4095, 12'd0, 12'hc00);
		send_vertex(16'h1234, 16'h4321, 16'h2000);
		send_vertex(16'h8000, 16'h7fff, 16'h7fff);
		drain();
		write_reg(rpv_pkg::REG_WIDTH, 12'hc01);
		write_reg(rpv_pkg::REG_HEIGHT, 12'd1);
		write_reg(REG_SPARE, 12'hfff);
		send_vertex(16'h2000, 16'hf000, 16'h1000);
		send_vertex(16'h7fff, 16'h8000, 16'h0000);

		for (int q = 1; q < 4; q++) begin
			set_screen(12'(q * 1024), 12'd80, 12'd40);
			send_vertex(16'h2000, 16'h1000, 16'h0000);
			send_vertex(16'h0000, 16'hf000, 16'h2000);
		end

		set_screen(12'd0, 12'd100, 12'd24);
		random_burst(120);

		set_screen(12'd4095, 12'd1023, 12'd1023);
		random_burst(120);

		// Hold the receiver so the pipeline fills and stops taking vertices.
		set_screen(12'd1, 12'd1, 12'd1);
		tx_idle_pct = 0;
		rx_hold_cycles = 150;
		random_burst(60);
		tx_idle_pct = 55;
		rx_idle_pct = 38;

		set_screen(12'($urandom), 12'($urandom_range(1, 1023)),
			12'($urandom_range(1, 1023)));
		random_burst(120);
		drain();
		random_burst(60);

		set_screen(12'($urandom), 12'($urandom_range(1, 1023)),
			12'($urandom_range(1, 1023)));
		random_burst(130);

		set_screen(12'd2048, 12'd512, 12'd256);
		random_burst(120);

		drain();
		$display("Projected %0d vertices (%0d behind the viewer) over several angle and",
			points_seen, behind_seen);
		$display("screen settings, with random and long stalls on both streams.");
		if (errors == 0 && points_seen == sent) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
